// ----- hdl/spg_pkg.sv -----
`default_nettype none
package spg_pkg;

  // Timer period width and limits
  localparam int PERIOD_BITS = 16;
  localparam logic [PERIOD_BITS-1:0] MAX_PERIOD = '1;
  localparam logic [PERIOD_BITS-1:0] MIN_PERIOD = PERIOD_BITS'(100);

  // Field widths
  localparam int CLK_W   = 27;
  localparam int FREQ_W  = 20;
  localparam int STEPS_W = 32;
  localparam int NUM_W   = CLK_W + 1;
  localparam int QUO_W   = NUM_W;
  localparam int CNT_W   = $clog2(QUO_W);
  localparam int EXT_W   = 33;
  localparam int CFG_W   = CLK_W;
  localparam int IDX_W   = 2;

  // Stream word widths
  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 40;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_TIMER_CLK = 2'd0;
  localparam logic [IDX_W-1:0] REG_MIN_FREQ  = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAX_FREQ  = 2'd2;

  // Register reset values
  localparam logic [CLK_W-1:0]  TIMER_CLK_RST = CLK_W'(1000000);
  localparam logic [FREQ_W-1:0] MIN_FREQ_RST  = FREQ_W'(16);
  localparam logic [FREQ_W-1:0] MAX_FREQ_RST  = FREQ_W'(10000);

  // Request codes
  localparam logic [2:0] REQ_TICK       = 3'd0;
  localparam logic [2:0] REQ_START_FIN  = 3'd1;
  localparam logic [2:0] REQ_START_CONT = 3'd2;
  localparam logic [2:0] REQ_STOP       = 3'd3;
  localparam logic [2:0] REQ_SET_DIR    = 3'd4;
  localparam logic [2:0] REQ_QUERY      = 3'd5;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_ERR,
    CMD_START_FIN,
    CMD_START_CONT,
    CMD_STOP,
    CMD_SET_DIR,
    CMD_QUERY
  } cmd_kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BUSY = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    B_EXEC,
    B_DIV,
    B_LOAD
  } back_state_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [STEPS_W-1:0] step_count;
    logic [FREQ_W-1:0]  frequency;
    logic               dir_level;
  } cmd_t;

  typedef struct packed {
    logic [STEPS_W-1:0] steps_left;
    logic               continuous_flag;
    logic               busy_flag;
    logic               dir_out;
    logic               step_level;
    status_t            status;
  } res_t;

  // Clamp a rounded quotient to the legal period range
  function automatic logic [PERIOD_BITS-1:0] clamp_period(input logic [QUO_W-1:0] q);
    logic [EXT_W-1:0] qe;
    logic [PERIOD_BITS-1:0] p;
    qe = EXT_W'(q);
    if (qe < EXT_W'(MIN_PERIOD)) begin
      p = MIN_PERIOD;
    end else if (qe > EXT_W'(MAX_PERIOD)) begin
      p = MAX_PERIOD;
    end else begin
      p = qe[PERIOD_BITS-1:0];
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/stepper_step_pulse_generator.sv -----
// Single-axis STEP pulse generator.
// Request words enter on s_axis: tuser carries the request code, tdata the
// axis, step count, frequency and direction level. Every request word gives
// exactly one result word on m_axis with status, STEP and DIR levels, busy
// and continuous flags and the remaining step count.
// A tick word advances the period down-counter by one timer clock.
// The result word is registered: a taken request word passes through the
// command queue and then the output register. A start with a nonzero
// frequency that loads a new period also runs a restoring divider for the
// period, one quotient bit a cycle, and holds the back end for the pop,
// 28 divide steps and the load. Back-to-back ticks are taken and answered at
// one word per cycle while m_axis_tready stays high; words behind a start
// wait in the two-entry command queue while the divider runs.
// The user must write configuration (timer clock, frequency limits) via cfg_we,
// cfg_index, cfg_data only while no word is in flight; the block does not enforce it.
// Reset (rst, synchronous) stops the generator, clears the queue, drops any
// pending result word and restores the register defaults.
// A stall on m_axis_tready holds the result word; the queue then fills and
// s_axis_tready drops until the result is taken.
`default_nettype none
module stepper_step_pulse_generator (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [spg_pkg::IDX_W-1:0]        cfg_index,
  input  wire logic [spg_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [1:0] axis, [33:2] step_count, [53:34] frequency, [54] dir_level
  input  wire logic [spg_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [2:0] req_type
  input  wire logic [spg_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [1:0] status, [2] step_level, [3] dir_out, [4] busy_flag,
  // [5] continuous_flag, [37:6] steps_left
  output logic [spg_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);

  logic                        q_full;
  logic                        q_push;
  logic                        q_pop;
  logic                        q_valid;
  spg_pkg::cmd_t               q_cmd;
  spg_pkg::cmd_t               q_head;
  logic [spg_pkg::CLK_W-1:0]   timer_clk_hz;

  // Accept and classify request words
  spg_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_cmd),
    .timer_clk_hz  (timer_clk_hz)
  );

  // Decouple front and back
  spg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // Run commands and drive results
  spg_back u_back (
    .clk           (clk),
    .rst           (rst),
    .timer_clk_hz  (timer_clk_hz),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire

// ----- hdl/spg_front.sv -----
`default_nettype none
module spg_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [spg_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [spg_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [spg_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  wire logic [spg_pkg::IN_USER_W-1:0] s_axis_tuser,
  input  wire logic                          q_full,
  output logic                               q_push,
  output spg_pkg::cmd_t                      q_cmd,
  output logic [spg_pkg::CLK_W-1:0]          timer_clk_hz
);

  logic [spg_pkg::FREQ_W-1:0] min_freq_hz;
  logic [spg_pkg::FREQ_W-1:0] max_freq_hz;
  logic [1:0]                 axis;
  logic [spg_pkg::FREQ_W-1:0] freq;
  logic                       freq_ok;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_clk_hz <= spg_pkg::TIMER_CLK_RST;
      min_freq_hz  <= spg_pkg::MIN_FREQ_RST;
      max_freq_hz  <= spg_pkg::MAX_FREQ_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        spg_pkg::REG_TIMER_CLK: timer_clk_hz <= cfg_data;
        spg_pkg::REG_MIN_FREQ:  min_freq_hz  <= cfg_data[spg_pkg::FREQ_W-1:0];
        spg_pkg::REG_MAX_FREQ:  max_freq_hz  <= cfg_data[spg_pkg::FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;

  assign axis    = s_axis_tdata[1:0];
  assign freq    = s_axis_tdata[53:34];
  assign freq_ok = (freq >= min_freq_hz) && (freq <= max_freq_hz);

  // Classify the word
  always_comb begin
    q_cmd.step_count = s_axis_tdata[33:2];
    q_cmd.frequency  = freq;
    q_cmd.dir_level  = s_axis_tdata[54];
    q_cmd.kind       = spg_pkg::CMD_ERR;
    if (s_axis_tuser == spg_pkg::REQ_TICK) begin
      q_cmd.kind = spg_pkg::CMD_TICK;
    end else if (axis == 2'd0) begin
      case (s_axis_tuser)
        spg_pkg::REQ_START_FIN:
          q_cmd.kind = freq_ok ? spg_pkg::CMD_START_FIN : spg_pkg::CMD_ERR;
        spg_pkg::REQ_START_CONT:
          q_cmd.kind = freq_ok ? spg_pkg::CMD_START_CONT : spg_pkg::CMD_ERR;
        spg_pkg::REQ_STOP:    q_cmd.kind = spg_pkg::CMD_STOP;
        spg_pkg::REQ_SET_DIR: q_cmd.kind = spg_pkg::CMD_SET_DIR;
        spg_pkg::REQ_QUERY:   q_cmd.kind = spg_pkg::CMD_QUERY;
        default:              q_cmd.kind = spg_pkg::CMD_ERR;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/spg_queue.sv -----
`default_nettype none
module spg_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire spg_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               valid,
  output spg_pkg::cmd_t      head
);

  spg_pkg::cmd_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = mem[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/spg_back.sv -----
`default_nettype none
module spg_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [spg_pkg::CLK_W-1:0]      timer_clk_hz,
  input  wire logic                           q_valid,
  input  wire spg_pkg::cmd_t                  q_head,
  output logic                                q_pop,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [spg_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

  localparam int PB = spg_pkg::PERIOD_BITS;
  localparam int SW = spg_pkg::STEPS_W;
  localparam int FW = spg_pkg::FREQ_W;
  localparam int QW = spg_pkg::QUO_W;

  // Generator state
  logic [PB-1:0] period_count, period_count_next;
  logic [PB-1:0] reload_value, reload_value_next;
  logic [PB-1:0] half_period, half_period_next;
  logic [SW-1:0] remaining, remaining_next;
  logic          running, running_next;
  logic          free_run, free_run_next;
  logic          direction, direction_next;

  // Sequencer and divider
  spg_pkg::back_state_t state, state_next;
  spg_pkg::cmd_t        cur, cmd;
  logic [QW-1:0]        num_sh;
  logic [FW-1:0]        rem;
  logic [QW-1:0]        quo;
  logic [spg_pkg::CNT_W-1:0] cnt;
  logic [FW:0]          trial;
  logic                 trial_ge;

  // Output register
  spg_pkg::res_t out_res;
  spg_pkg::res_t res_next;
  logic          out_free;
  logic          commit;
  logic          div_start;
  logic          need_div;
  logic [PB-1:0] p_in;
  logic [SW-1:0] rem_dec;
  spg_pkg::status_t st;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata = {{(spg_pkg::OUT_DATA_W - $bits(spg_pkg::res_t)){1'b0}}, out_res};

  assign trial    = {rem, num_sh[QW-1]};
  assign trial_ge = (trial >= {1'b0, cur.frequency});

  // Pick the command to run and decide whether it needs a divide
  always_comb begin
    cmd = (state == spg_pkg::B_LOAD) ? cur : q_head;
    p_in = (state == spg_pkg::B_LOAD) ? spg_pkg::clamp_period(quo) : spg_pkg::MAX_PERIOD;
    need_div = (q_head.frequency != '0) &&
               ((q_head.kind == spg_pkg::CMD_START_CONT) ||
                ((q_head.kind == spg_pkg::CMD_START_FIN) &&
                 (q_head.step_count != '0) && !running));
  end

  // Sequencer: next state and handshakes
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    commit     = 1'b0;
    div_start  = 1'b0;
    case (state)
      spg_pkg::B_EXEC: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (need_div) begin
            div_start  = 1'b1;
            state_next = spg_pkg::B_DIV;
          end else begin
            commit = 1'b1;
          end
        end
      end
      spg_pkg::B_DIV: begin
        if (cnt == '0) begin
          state_next = spg_pkg::B_LOAD;
        end
      end
      spg_pkg::B_LOAD: begin
        if (out_free) begin
          commit     = 1'b1;
          state_next = spg_pkg::B_EXEC;
        end
      end
      default: state_next = spg_pkg::B_EXEC;
    endcase
  end

  // Execute one command against the generator state
  always_comb begin
    period_count_next = period_count;
    reload_value_next = reload_value;
    half_period_next  = half_period;
    remaining_next    = remaining;
    running_next      = running;
    free_run_next     = free_run;
    direction_next    = direction;
    st                = spg_pkg::ST_OK;
    rem_dec           = remaining;
    case (cmd.kind)
      spg_pkg::CMD_TICK: begin
        if (running) begin
          if (period_count == '0) begin
            if (!free_run && (remaining != '0)) begin
              rem_dec = remaining - SW'(1);
            end
            remaining_next = rem_dec;
            if (!free_run && (rem_dec == '0)) begin
              running_next   = 1'b0;
              free_run_next  = 1'b0;
              remaining_next = '0;
            end else begin
              period_count_next = reload_value;
            end
          end else begin
            period_count_next = period_count - PB'(1);
          end
        end
      end
      spg_pkg::CMD_START_FIN: begin
        if (cmd.step_count == '0) begin
          running_next   = 1'b0;
          free_run_next  = 1'b0;
          remaining_next = '0;
        end else if (running) begin
          st = spg_pkg::ST_BUSY;
        end else begin
          reload_value_next = p_in - PB'(1);
          period_count_next = p_in - PB'(1);
          half_period_next  = p_in >> 1;
          remaining_next    = cmd.step_count;
          free_run_next     = 1'b0;
          running_next      = 1'b1;
        end
      end
      spg_pkg::CMD_START_CONT: begin
        direction_next    = cmd.dir_level;
        reload_value_next = p_in - PB'(1);
        period_count_next = p_in - PB'(1);
        half_period_next  = p_in >> 1;
        remaining_next    = '1;
        free_run_next     = 1'b1;
        running_next      = 1'b1;
      end
      spg_pkg::CMD_STOP: begin
        running_next   = 1'b0;
        free_run_next  = 1'b0;
        remaining_next = '0;
      end
      spg_pkg::CMD_SET_DIR: begin
        if (running) begin
          st = spg_pkg::ST_BUSY;
        end else begin
          direction_next = cmd.dir_level;
        end
      end
      spg_pkg::CMD_QUERY: ;
      default: st = spg_pkg::ST_ERR;
    endcase
    res_next.status          = st;
    res_next.step_level      = running_next && (period_count_next < half_period_next);
    res_next.dir_out         = direction_next;
    res_next.busy_flag       = running_next;
    res_next.continuous_flag = free_run_next;
    res_next.steps_left      = remaining_next;
  end

  // Control and generator state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= spg_pkg::B_EXEC;
      m_axis_tvalid <= 1'b0;
      period_count  <= '0;
      reload_value  <= '0;
      half_period   <= '0;
      remaining     <= '0;
      running       <= 1'b0;
      free_run      <= 1'b0;
      direction     <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        m_axis_tvalid <= 1'b1;
        period_count  <= period_count_next;
        reload_value  <= reload_value_next;
        half_period   <= half_period_next;
        remaining     <= remaining_next;
        running       <= running_next;
        free_run      <= free_run_next;
        direction     <= direction_next;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (commit) begin
      out_res <= res_next;
    end
  end

  // Restoring divider: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (div_start) begin
      cur    <= q_head;
      num_sh <= QW'(timer_clk_hz) + QW'(q_head.frequency >> 1);
      rem    <= '0;
      quo    <= '0;
      cnt    <= spg_pkg::CNT_W'(QW - 1);
    end else if (state == spg_pkg::B_DIV) begin
      num_sh <= num_sh << 1;
      quo    <= {quo[QW-2:0], trial_ge};
      rem    <= trial_ge ? FW'(trial - {1'b0, cur.frequency}) : trial[FW-1:0];
      cnt    <= cnt - spg_pkg::CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

// ----- verif/stepper_step_pulse_generator_check.sv -----
// Watches both stream channels and the register port, keeps its own copy of
// the pulse generator state and compares every result word with the oldest
// predicted word.
module stepper_step_pulse_generator_check (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [spg_pkg::IDX_W-1:0]      cfg_index,
  input  wire logic [spg_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                           s_axis_tvalid,
  input  wire logic                           s_axis_tready,
  // [1:0] axis, [33:2] step_count, [53:34] frequency, [54] dir_level
  input  wire logic [spg_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [2:0] req_type
  input  wire logic [spg_pkg::IN_USER_W-1:0]  s_axis_tuser,
  input  wire logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [1:0] status, [2] step_level, [3] dir_out, [4] busy_flag,
  // [5] continuous_flag, [37:6] steps_left
  input  wire logic [spg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output int                                  fail_count,
  output int                                  outstanding
);
  import spg_pkg::*;

  localparam int PB = PERIOD_BITS;

  // Register copies
  logic [CLK_W-1:0]   tclk_hz;
  logic [FREQ_W-1:0]  fmin_hz;
  logic [FREQ_W-1:0]  fmax_hz;

  // Generator state
  logic [PB-1:0]      step_cnt;
  logic [PB-1:0]      reload_val;
  logic [PB-1:0]      half_val;
  logic [STEPS_W-1:0] steps_rem;
  logic               running;
  logic               cont_mode;
  logic               dir_level;

  res_t expected_words[$];
  int   word_no;

  function automatic void stop_run();
    running   = 1'b0;
    cont_mode = 1'b0;
    steps_rem = '0;
  endfunction

  function automatic logic freq_ok(logic [FREQ_W-1:0] f);
    return f >= fmin_hz && f <= fmax_hz;
  endfunction

  // Round timer clock / f to a period (the longest for a zero f), clamp it and restart the down-counter
  function automatic void arm_period(logic [FREQ_W-1:0] f);
    logic [63:0]   q;
    logic [PB-1:0] p;
    if (f == '0) begin
      p = MAX_PERIOD;
    end else begin
      q = (64'(tclk_hz) + 64'(f >> 1)) / 64'(f);
      if (q < 64'(MIN_PERIOD)) p = MIN_PERIOD;
      else if (q > 64'(MAX_PERIOD)) p = MAX_PERIOD;
      else p = q[PB-1:0];
    end
    reload_val = p - 1'b1;
    step_cnt   = reload_val;
    half_val   = p >> 1;
  endfunction

  // Apply one request word to the state and build the result word it gives
  function automatic res_t advance_generator(logic [2:0] req, logic [1:0] axis,
                                             logic [STEPS_W-1:0] steps,
                                             logic [FREQ_W-1:0] freq, logic lvl);
    res_t    r;
    status_t st;
    st = ST_OK;
    if (req == REQ_TICK) begin
      if (running) begin
        if (step_cnt == '0) begin
          if (!cont_mode && steps_rem != '0) steps_rem = steps_rem - 1'b1;
          if (!cont_mode && steps_rem == '0) stop_run();
          else step_cnt = reload_val;
        end else begin
          step_cnt = step_cnt - 1'b1;
        end
      end
    end else if (req > REQ_QUERY || axis != 2'd0) begin
      st = ST_ERR;
    end else if (req == REQ_START_FIN) begin
      if (!freq_ok(freq)) begin
        st = ST_ERR;
      end else if (steps == '0) begin
        stop_run();
      end else if (running) begin
        st = ST_BUSY;
      end else begin
        arm_period(freq);
        steps_rem = steps;
        cont_mode = 1'b0;
        running   = 1'b1;
      end
    end else if (req == REQ_START_CONT) begin
      if (!freq_ok(freq)) begin
        st = ST_ERR;
      end else begin
        stop_run();
        dir_level = lvl;
        arm_period(freq);
        steps_rem = '1;
        cont_mode = 1'b1;
        running   = 1'b1;
      end
    end else if (req == REQ_STOP) begin
      stop_run();
    end else if (req == REQ_SET_DIR) begin
      if (running) st = ST_BUSY;
      else dir_level = lvl;
    end
    r.status          = st;
    r.step_level      = running && (step_cnt < half_val);
    r.dir_out         = dir_level;
    r.busy_flag       = running;
    r.continuous_flag = cont_mode;
    r.steps_left      = steps_rem;
    return r;
  endfunction

  task automatic note_failure(string why, res_t want, res_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("word %0d %s: expected st=%0d step=%0b dir=%0b busy=%0b cont=%0b left=%0h,",
               word_no, why, want.status, want.step_level, want.dir_out, want.busy_flag,
               want.continuous_flag, want.steps_left,
               "  got st=%0d step=%0b dir=%0b busy=%0b cont=%0b left=%0h",
               got.status, got.step_level, got.dir_out, got.busy_flag,
               got.continuous_flag, got.steps_left);
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      tclk_hz    = TIMER_CLK_RST;
      fmin_hz    = MIN_FREQ_RST;
      fmax_hz    = MAX_FREQ_RST;
      step_cnt   = '0;
      reload_val = '0;
      half_val   = '0;
      steps_rem  = '0;
      running    = 1'b0;
      cont_mode  = 1'b0;
      dir_level  = 1'b0;
      word_no    = 0;
      expected_words.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_TIMER_CLK: tclk_hz = cfg_data;
          REG_MIN_FREQ:  fmin_hz = cfg_data[FREQ_W-1:0];
          REG_MAX_FREQ:  fmax_hz = cfg_data[FREQ_W-1:0];
          default: ;
        endcase
      end
      // Predict the word for each accepted request
      if (s_axis_tvalid && s_axis_tready)
        expected_words.push_back(advance_generator(s_axis_tuser[2:0], s_axis_tdata[1:0],
                                                   s_axis_tdata[33:2], s_axis_tdata[53:34],
                                                   s_axis_tdata[54]));
      // Compare each accepted result word with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
        if (expected_words.size() == 0) begin
          note_failure("arrived with nothing pending", '0, got);
        end else begin
          want = expected_words.pop_front();
          if (got.status !== want.status || got.step_level !== want.step_level ||
              got.dir_out !== want.dir_out || got.busy_flag !== want.busy_flag ||
              got.continuous_flag !== want.continuous_flag ||
              got.steps_left !== want.steps_left)
            note_failure("mismatch", want, got);
        end
        word_no++;
      end
    end
    outstanding <= expected_words.size();
  end

endmodule

// ----- verif/stepper_step_pulse_generator_test.sv -----
module stepper_step_pulse_generator_test;
  import spg_pkg::*;

  // Request codes the block does not know
  localparam logic [2:0] REQ_RSVD_LO = 3'd6;
  localparam logic [2:0] REQ_RSVD_HI = 3'd7;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 245;
  localparam int LONG_HOLD   = 400;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  int                    fail_count;
  int                    outstanding;

  int cycle_no   = 0;
  int item_total = 0;
  int sink_hold  = 0;
  bit src_calm   = 1'b0;
  bit sink_calm  = 1'b0;
  logic [FREQ_W-1:0] cur_min = MIN_FREQ_RST;
  logic [FREQ_W-1:0] cur_max = MAX_FREQ_RST;

  stepper_step_pulse_generator dut (.*);

  stepper_step_pulse_generator_check watch (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // Give up after a generous number of cycles
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one request word after a random gap and hold it until taken
  task automatic send_req(logic [2:0] req, logic [1:0] axis, logic [STEPS_W-1:0] steps,
                          logic [FREQ_W-1:0] freq, logic lvl);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {1'b0, lvl, freq, steps, axis};
    do @(posedge clk); while (!s_axis_tready);
    item_total++;
  endtask

  // Frequencies: mostly legal and short-period, plus the edges of the window
  function automatic logic [FREQ_W-1:0] pick_freq();
    int unsigned       r;
    logic [FREQ_W-1:0] span;
    r = $urandom_range(0, 11);
    span = cur_max - cur_min;
    if (cur_min > cur_max || r == 11) return FREQ_W'($urandom);
    if (r < 4) return FREQ_W'($urandom_range(cur_max, cur_max - span / 8));
    if (r < 7) return FREQ_W'($urandom_range(cur_max, cur_min));
    if (r == 7) return cur_min - 1'b1;
    if (r == 8) return cur_max + 1'b1;
    if (r == 9) return cur_min;
    return cur_max;
  endfunction

  task automatic send_noise();
    send_req(3'($urandom_range(0, 7)),
             $urandom_range(0, 1) ? 2'd0 : 2'($urandom_range(0, 3)),
             $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3),
             pick_freq(), 1'($urandom));
  endtask

  // Hold the sender until every word has come back
  task automatic flush_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(logic [CLK_W-1:0] tclk, logic [FREQ_W-1:0] fmin,
                               logic [FREQ_W-1:0] fmax);
    flush_results();
    cfg_we    <= 1'b1;
    cfg_index <= REG_TIMER_CLK;
    cfg_data  <= tclk;
    @(posedge clk);
    cfg_index <= REG_MIN_FREQ;
    cfg_data  <= CFG_W'(fmin);
    @(posedge clk);
    cfg_index <= REG_MAX_FREQ;
    cfg_data  <= CFG_W'(fmax);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_min = fmin;
    cur_max = fmax;
  endtask

  // Mostly a start followed by a run of ticks, with stray words mixed in
  task automatic run_phase(int quota);
    int stop_at;
    int n;
    stop_at = item_total + quota;
    while (item_total < stop_at) begin
      src_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 1))
          send_req(REQ_START_FIN, 2'd0, $urandom_range(1, 3), pick_freq(), 1'($urandom));
        else
          send_req(REQ_START_CONT, 2'd0, $urandom, pick_freq(), 1'($urandom));
        n = $urandom_range(20, 250);
        // Keep the phase close to its quota
        if (n > stop_at - item_total) n = stop_at - item_total;
        repeat (n) begin
          if ($urandom_range(0, 39) == 0)
            send_noise();
          else
            send_req(REQ_TICK, 2'($urandom), $urandom, FREQ_W'($urandom), 1'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 6)) send_noise();
      end
    end
  endtask

  // Result side: random stalls, calm stretches and an occasional long hold
  initial begin
    int n;
    do @(posedge clk); while (rst);
    forever begin
      if (sink_hold > 0) begin
        n = sink_hold;
        sink_hold = 0;
      end else begin
        n = sink_calm ? 0 : $urandom_range(0, 7);
      end
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      if ($urandom_range(0, 31) == 0) sink_calm = !sink_calm;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed words under the reset settings
    send_req(REQ_QUERY,      2'd0, '0, '0, 1'b0);
    send_req(REQ_QUERY,      2'd3, '0, '0, 1'b0);
    send_req(REQ_TICK,       2'd3, 32'hFFFF_FFFF, 20'hFFFFF, 1'b1);
    send_req(REQ_SET_DIR,    2'd0, '0, '0, 1'b1);
    send_req(REQ_START_FIN,  2'd0, 32'd5, 20'd15, 1'b0);
    send_req(REQ_START_FIN,  2'd0, 32'd5, 20'd10001, 1'b0);
    send_req(REQ_START_CONT, 2'd0, '0, 20'hFFFFF, 1'b1);
    send_req(REQ_START_FIN,  2'd0, '0, 20'd100, 1'b0);
    send_req(REQ_START_FIN,  2'd0, 32'hFFFF_FFFF, 20'd10000, 1'b0);
    send_req(REQ_START_FIN,  2'd0, 32'd7, 20'd10000, 1'b0);
    send_req(REQ_SET_DIR,    2'd0, '0, '0, 1'b0);
    repeat (3) send_req(REQ_TICK, 2'd0, '0, '0, 1'b0);
    send_req(REQ_STOP,       2'd2, '0, '0, 1'b0);
    send_req(REQ_STOP,       2'd0, '0, '0, 1'b0);
    send_req(REQ_START_CONT, 2'd0, '0, 20'd16, 1'b1);
    send_req(REQ_START_CONT, 2'd1, '0, 20'd5000, 1'b0);
    send_req(REQ_START_CONT, 2'd0, '0, 20'd10000, 1'b0);
    send_req(REQ_TICK,       2'd0, '0, '0, 1'b0);
    send_req(REQ_START_FIN,  2'd0, '0, 20'd10000, 1'b0);
    send_req(REQ_RSVD_LO,    2'd0, '0, '0, 1'b0);
    send_req(REQ_RSVD_HI,    2'd0, '0, '0, 1'b0);
    send_req(REQ_START_FIN,  2'd0, 32'd1, 20'd10000, 1'b1);
    send_req(REQ_STOP,       2'd0, '0, '0, 1'b0);

    // Reset settings, with a long result-side hold to back up the input
    sink_hold = LONG_HOLD;
    run_phase(PHASE_ITEMS);

    // Fastest clock, single-point window at the top of the range
    load_settings(27'd100000000, 20'hFFFFF, 20'hFFFFF);
    run_phase(PHASE_ITEMS);

    // Slowest clock with a zero frequency let through
    load_settings(27'd1, 20'd0, 20'hFFFFF);
    send_req(REQ_START_CONT, 2'd0, '0, 20'd0, 1'b1);
    send_req(REQ_TICK,       2'd0, '0, '0, 1'b0);
    run_phase(PHASE_ITEMS);

    // Inverted window: every start refused
    load_settings(27'd5000, 20'd300000, 20'd20);
    run_phase(PHASE_ITEMS);

    // Periods that clamp at both ends
    load_settings(27'd3000000, 20'd1, 20'd65535);
    sink_hold = LONG_HOLD;
    run_phase(PHASE_ITEMS);

    load_settings(TIMER_CLK_RST, MIN_FREQ_RST, MAX_FREQ_RST);
    run_phase(PHASE_ITEMS);

    flush_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
